// ===== sv/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_LOOP,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_REM,
    S_DEL_LOOP,
    S_DEL_WR,
    S_LOC_LOOP,
    S_LOC_CMP,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== sv/slt_ram.sv =====
`default_nettype none

// Single write port, single read port storage with registered read data.
module slt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sequential_list_table.sv =====
`default_nettype none

// Channel   Handshake              Payload
// req       req_valid/req_ready    op, position, value
// rsp       rsp_valid/rsp_ready    status, removed_value, found_position, list_length
//
// Entries live in a one-read, one-write RAM and every move goes through its single port pair.
// Clear and rejected requests go straight from idle to the finish state; insert, delete
// and locate step through the entries, and locate stops at the first match.
// Each shifted entry costs one RAM read and one RAM write.
// Reset clears the length and the handshake state only; the RAM needs no clearing.
// req_ready is high only when the sequencer is idle; a finished result waits in its own
// registers, so a new transaction may be taken while rsp_valid is stalled.
module sequential_list_table
  import slt_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  op,
  input  wire logic [6:0]  position,
  input  wire logic [31:0] value,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [1:0]       status,
  output logic [31:0]      removed_value,
  output logic [6:0]       found_position,
  output logic [6:0]       list_length
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > 7) ? CW : 7) + 1;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;
  logic [6:0]            pos_r, pos_r_next;
  logic [ELEM_WIDTH-1:0] val_r, val_r_next;
  logic [1:0]            res_status, res_status_next;
  logic [31:0]           res_removed, res_removed_next;
  logic [6:0]            res_found, res_found_next;
  logic                  rsp_valid_next;
  logic [1:0]            status_next;
  logic [31:0]           removed_value_next;
  logic [6:0]            found_position_next;
  logic [6:0]            list_length_next;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  logic [WW-1:0]         pos_in_w;
  logic [WW-1:0]         pos_r_w;
  logic [WW-1:0]         count_w;

  slt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign pos_in_w  = WW'(position);
  assign pos_r_w   = WW'(pos_r);
  assign count_w   = WW'(count);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx            <= idx_next;
    pos_r          <= pos_r_next;
    val_r          <= val_r_next;
    res_status     <= res_status_next;
    res_removed    <= res_removed_next;
    res_found      <= res_found_next;
    status         <= status_next;
    removed_value  <= removed_value_next;
    found_position <= found_position_next;
    list_length    <= list_length_next;
  end

  // Sequencer: next state, RAM control and result staging.
  always_comb begin
    state_next          = state;
    count_next          = count;
    idx_next            = idx;
    pos_r_next          = pos_r;
    val_r_next          = val_r;
    res_status_next     = res_status;
    res_removed_next    = res_removed;
    res_found_next      = res_found;
    rsp_valid_next      = rsp_valid;
    status_next         = status;
    removed_value_next  = removed_value;
    found_position_next = found_position;
    list_length_next    = list_length;
    mem_we              = 1'b0;
    mem_waddr           = AW'(idx);
    mem_wdata           = mem_rdata;
    mem_raddr           = AW'(idx);

    // The response register empties when its transaction is taken.
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          pos_r_next       = position;
          val_r_next       = ELEM_WIDTH'(value);
          res_status_next  = STAT_OK;
          res_removed_next = '0;
          res_found_next   = '0;
          unique case (op_t'(op))
            OP_INSERT: begin
              if (position == 7'd0 || pos_in_w > count_w + WW'(1)) begin
                res_status_next = STAT_RANGE;
                state_next      = S_FINISH;
              end else if (count_w == WW'(DEPTH)) begin
                res_status_next = STAT_FULL;
                state_next      = S_FINISH;
              end else begin
                idx_next   = count;
                state_next = S_INS_LOOP;
              end
            end
            OP_DELETE: begin
              if (position == 7'd0 || pos_in_w > count_w) begin
                res_status_next = STAT_RANGE;
                state_next      = S_FINISH;
              end else begin
                state_next = S_DEL_RD;
              end
            end
            OP_LOCATE: begin
              idx_next   = '0;
              state_next = S_LOC_LOOP;
            end
            OP_CLEAR: begin
              count_next = '0;
              state_next = S_FINISH;
            end
          endcase
        end
      end

      // Move entries up from the tail until the gap reaches the position.
      S_INS_LOOP: begin
        if (WW'(idx) >= pos_r_w) begin
          mem_raddr  = AW'(idx - CW'(1));
          state_next = S_INS_WR;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = AW'(pos_r_w - WW'(1));
          mem_wdata  = val_r;
          count_next = count + CW'(1);
          state_next = S_FINISH;
        end
      end

      S_INS_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(idx);
        idx_next   = idx - CW'(1);
        state_next = S_INS_LOOP;
      end

      // Fetch the entry being removed.
      S_DEL_RD: begin
        mem_raddr  = AW'(pos_r_w - WW'(1));
        state_next = S_DEL_REM;
      end

      S_DEL_REM: begin
        res_removed_next = 32'(mem_rdata);
        idx_next         = CW'(pos_r_w);
        state_next       = S_DEL_LOOP;
      end

      // Move the later entries down one place each.
      S_DEL_LOOP: begin
        if (idx < count) begin
          mem_raddr  = AW'(idx);
          state_next = S_DEL_WR;
        end else begin
          count_next = count - CW'(1);
          state_next = S_FINISH;
        end
      end

      S_DEL_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(idx - CW'(1));
        idx_next   = idx + CW'(1);
        state_next = S_DEL_LOOP;
      end

      // Linear search from the head for the first equal entry.
      S_LOC_LOOP: begin
        if (idx < count) begin
          mem_raddr  = AW'(idx);
          state_next = S_LOC_CMP;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_LOC_CMP: begin
        if (mem_rdata == val_r) begin
          res_found_next = 7'(idx + CW'(1));
          state_next     = S_FINISH;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_LOC_LOOP;
        end
      end

      // Hand the result over once the response register is free.
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next      = 1'b1;
          status_next         = res_status;
          removed_value_next  = res_removed;
          found_position_next = res_found;
          list_length_next    = 7'(count);
          state_next          = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
